>>> design/pafq_pkg.sv
// Shared widths, register indexes and lane control type for the PWM audio frame quantizer.
package pafq_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DUTY_W   = 15;
  localparam int FRAC_W   = 16;
  localparam int MULT_W   = 2 * SAMPLE_W;
  localparam int PROD_W   = MULT_W + 1;
  localparam int ACC_W    = PROD_W + 1;
  localparam int QUOT_W   = ACC_W - FRAC_W;
  localparam int HALF_SHIFT = SAMPLE_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = DUTY_W;

  localparam logic [DUTY_W-1:0] FULL_SCALE_RESET = DUTY_W'(5208);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE  = 3'd0,
    REG_MUTE_LEFT   = 3'd1,
    REG_MUTE_RIGHT  = 3'd2,
    REG_STEREO_PIN  = 3'd3,
    REG_MONO_SOURCE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic update;
  } lane_ctl_t;

endpackage

>>> design/pafq_lane.sv
// One requantizer lane: registered scale multiply, then residue add, clamp and feedback.
module pafq_lane import pafq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic        [DUTY_W-1:0]   full_scale,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  lane_ctl_t                  ctl,
  output logic        [DUTY_W-1:0]   duty
);

  logic signed [MULT_W-1:0] mult;
  logic signed [PROD_W-1:0] offset;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic        [FRAC_W-1:0] residue;
  logic        [FRAC_W-1:0] residue_next;
  logic signed [ACC_W-1:0]  acc;
  logic        [QUOT_W-1:0] quot;
  logic                     negative;
  logic                     over;

  always_comb begin
    mult      = MULT_W'(sample) * MULT_W'(signed'({1'b0, full_scale}));
    offset    = signed'(PROD_W'({full_scale, {HALF_SHIFT{1'b0}}}));
    prod_next = PROD_W'(mult) + offset;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    acc      = ACC_W'(prod) + signed'(ACC_W'(residue));
    negative = acc[ACC_W-1];
    quot     = acc[ACC_W-1:FRAC_W];
    over     = quot > QUOT_W'(full_scale);
    if (negative) begin
      duty         = '0;
      residue_next = '0;
    end else if (over) begin
      duty         = full_scale;
      residue_next = '0;
    end else begin
      duty         = quot[DUTY_W-1:0];
      residue_next = acc[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue <= '0;
    end else if (ctl.step && ctl.update) begin
      residue <= residue_next;
    end
  end

endmodule

>>> design/pwm_audio_frame_quantizer.sv
// Top level: configuration registers, source selection, two requantizer lanes and output merge.
// An accepted frame is held in the multiply register and then in the output register, where its duty pair is valid.
// Throughput: one frame per cycle unless out_ready stalls; each lane's residue feedback loop holds one register.
// The multiply stage and the output register each hold one frame, so ready drops only on stall.
// Reset clears the residues and all valid flags and restores the default register values.
module pwm_audio_frame_quantizer import pafq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   left_sample,
  input  logic signed [SAMPLE_W-1:0]   right_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [DUTY_W-1:0]     duty_left,
  output logic        [DUTY_W-1:0]     duty_right
);

  logic [DUTY_W-1:0] full_scale;
  logic              mute_left;
  logic              mute_right;
  logic              stereo_pin;
  logic              mono_source;

  logic              a_valid;
  logic              a_stereo;
  logic              a_load;
  logic              b_load;

  logic signed [SAMPLE_W-1:0] left_x;
  logic signed [SAMPLE_W-1:0] right_x;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] sum_sat;
  logic signed [SAMPLE_W-1:0] left_src;

  lane_ctl_t         left_ctl;
  lane_ctl_t         right_ctl;
  logic [DUTY_W-1:0] left_duty;
  logic [DUTY_W-1:0] right_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale  <= FULL_SCALE_RESET;
      mute_left   <= 1'b0;
      mute_right  <= 1'b0;
      stereo_pin  <= 1'b0;
      mono_source <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FULL_SCALE:  full_scale  <= cfg_data[DUTY_W-1:0];
        REG_MUTE_LEFT:   mute_left   <= cfg_data[0];
        REG_MUTE_RIGHT:  mute_right  <= cfg_data[0];
        REG_STEREO_PIN:  stereo_pin  <= cfg_data[0];
        REG_MONO_SOURCE: mono_source <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    left_x  = mute_left  ? '0 : left_sample;
    right_x = mute_right ? '0 : right_sample;
    sum     = (SAMPLE_W+1)'(left_x) + (SAMPLE_W+1)'(right_x);
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sum_sat = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
    left_src = (stereo_pin || mono_source) ? left_x : sum_sat;
  end

  assign b_load   = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || b_load;
  assign a_load   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_stereo <= stereo_pin;
    end
  end

  always_comb begin
    left_ctl.load    = a_load;
    left_ctl.step    = b_load;
    left_ctl.update  = 1'b1;
    right_ctl.load   = a_load;
    right_ctl.step   = b_load;
    right_ctl.update = a_stereo;
  end

  pafq_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .full_scale (full_scale),
    .sample     (left_src),
    .ctl        (left_ctl),
    .duty       (left_duty)
  );

  pafq_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .full_scale (full_scale),
    .sample     (right_x),
    .ctl        (right_ctl),
    .duty       (right_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      duty_left  <= left_duty;
      duty_right <= a_stereo ? right_duty : left_duty;
    end
  end

endmodule
